// ----- design/tool_frame_decoder_defines.svh -----
// Assertion macros used by the tool frame decoder top level.
`ifndef TOOL_FRAME_DECODER_DEFINES_SVH
`define TOOL_FRAME_DECODER_DEFINES_SVH

// Checked on every rising clk edge outside of reset.
`define TFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clk edge, reset cycles included.
`define TFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/tfd_pkg.sv -----
// Shared types and constants of the tool frame decoder.
`default_nettype none

package tfd_pkg;

  localparam int unsigned FORCE_W = 14;
  localparam int unsigned CNT_W   = 3;

  typedef logic [7:0]         frame_byte_t;
  typedef logic [FORCE_W-1:0] force_t;
  typedef logic [CNT_W-1:0]   count_t;

  typedef enum logic [1:0] {
    TOOL_NONE  = 2'd0,
    TOOL_BRUSH = 2'd1,
    TOOL_KNIFE = 2'd2,
    TOOL_PIP   = 2'd3
  } tool_t;

  localparam frame_byte_t ASCII_ZERO   = 8'h30;
  localparam frame_byte_t ASCII_NINE   = 8'h39;
  localparam frame_byte_t LETTER_BRUSH = 8'h62;
  localparam frame_byte_t LETTER_KNIFE = 8'h6b;
  localparam frame_byte_t LETTER_PIP   = 8'h70;
  localparam frame_byte_t HELD_CODE    = 8'h01;

  localparam count_t COUNTER_MAX      = 3'd7;
  localparam count_t THRESHOLD_RESET  = 3'd2;

  localparam force_t WEIGHT_THOUSANDS = 14'd1000;
  localparam force_t WEIGHT_HUNDREDS  = 14'd100;
  localparam force_t WEIGHT_TENS      = 14'd10;

  // Decoded view of one frame, handed from the frame checker to the top.
  typedef struct packed {
    logic   rejected;
    logic   held;
    tool_t  tool;
    force_t force_val;
  } decode_t;

endpackage

`default_nettype wire

// ----- design/tool_frame_decoder.sv -----
// Top level of the tool frame decoder: frame register, tool state and result register.
//
// Usage: each input word on the in_valid/in_ready channel is one complete
// six-byte tool frame (letter, held byte, four ASCII digits). Every accepted
// word yields exactly one result word on the out_valid/out_ready channel,
// carrying the active tool, the stored brush and knife forces and a reject
// flag that asks the sender to resync.
// Path: an accepted word lands in the frame register, and its result is
// loaded from there into the output register once that register is free or
// being emptied. Throughput: one word per cycle while out_ready stays high;
// the tool state update is a single pass of decode and counter logic between
// the frame register and the output register.
// Stalls: while out_ready is low the result holds; one further word may wait
// in the frame register, after which in_ready drops until the result is taken.
// Reset (rst, synchronous): both stages empty, no active tool, counter and
// forces zero, switch threshold back to 2.
// Configuration: cfg_we writes cfg_wdata into the switch threshold; write
// only while no word is in flight.
`default_nettype none

`include "tool_frame_decoder_defines.svh"

module tool_frame_decoder (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [2:0]             cfg_wdata,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0]             tool_letter,
  input  wire logic [7:0]             held_byte,
  input  wire logic [7:0]             digit_thousands,
  input  wire logic [7:0]             digit_hundreds,
  input  wire logic [7:0]             digit_tens,
  input  wire logic [7:0]             digit_ones,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [1:0]                  active_tool_out,
  output logic [tfd_pkg::FORCE_W-1:0] brush_force_out,
  output logic [tfd_pkg::FORCE_W-1:0] knife_force_out,
  output logic                        frame_rejected
);
  import tfd_pkg::*;

  // Configuration.
  count_t switch_threshold;

  // Frame register.
  logic        frame_valid;
  frame_byte_t frame_letter;
  frame_byte_t frame_held;
  frame_byte_t frame_d3;
  frame_byte_t frame_d2;
  frame_byte_t frame_d1;
  frame_byte_t frame_d0;

  // Tool state.
  tool_t  active_tool;
  tool_t  active_tool_next;
  count_t change_counter;
  count_t change_counter_next;
  force_t brush_force;
  force_t brush_force_next;
  force_t knife_force;
  force_t knife_force_next;

  decode_t dec;
  logic    advance;

  // The frame moves on whenever the output register is free or being emptied.
  assign advance  = frame_valid && (!out_valid || out_ready);
  assign in_ready = !frame_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      switch_threshold <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      switch_threshold <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (in_ready) begin
      frame_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      frame_letter <= tool_letter;
      frame_held   <= held_byte;
      frame_d3     <= digit_thousands;
      frame_d2     <= digit_hundreds;
      frame_d1     <= digit_tens;
      frame_d0     <= digit_ones;
    end
  end

  tfd_frame_check u_check (
    .tool_letter     (frame_letter),
    .held_byte       (frame_held),
    .digit_thousands (frame_d3),
    .digit_hundreds  (frame_d2),
    .digit_tens      (frame_d1),
    .digit_ones      (frame_d0),
    .dec             (dec)
  );

  // A held frame for another tool bumps the debounce counter (saturating);
  // a held frame for the active tool clears it. A release frame only drops
  // its tool when that tool is active. Rejected frames leave all state alone.
  always_comb begin
    active_tool_next    = active_tool;
    change_counter_next = change_counter;
    brush_force_next    = brush_force;
    knife_force_next    = knife_force;
    if (!dec.rejected) begin
      if (dec.held) begin
        if (active_tool != dec.tool) begin
          if (change_counter != COUNTER_MAX) begin
            change_counter_next = change_counter + count_t'(1);
          end
        end else begin
          change_counter_next = '0;
        end
        if (change_counter_next > switch_threshold) begin
          active_tool_next = dec.tool;
        end
        if (dec.tool == TOOL_BRUSH) begin
          brush_force_next = dec.force_val;
        end
        if (dec.tool == TOOL_KNIFE) begin
          knife_force_next = dec.force_val;
        end
      end else if (active_tool == dec.tool) begin
        active_tool_next = TOOL_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_tool    <= TOOL_NONE;
      change_counter <= '0;
      brush_force    <= '0;
      knife_force    <= '0;
    end else if (advance) begin
      active_tool    <= active_tool_next;
      change_counter <= change_counter_next;
      brush_force    <= brush_force_next;
      knife_force    <= knife_force_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      active_tool_out <= active_tool_next;
      brush_force_out <= brush_force_next;
      knife_force_out <= knife_force_next;
      frame_rejected  <= dec.rejected;
    end
  end

  `TFD_ASSERT(a_reject_keeps_state, (advance && dec.rejected) |=> ($stable(active_tool) && $stable(change_counter) && $stable(brush_force) && $stable(knife_force)), "rejected frame changed tool state")
  `TFD_ASSERT(a_idle_keeps_state, !advance |=> ($stable(active_tool) && $stable(change_counter)), "tool state changed without a frame")
  `TFD_ASSERT(a_result_matches_state, advance |=> (out_valid && (active_tool_out == active_tool) && (brush_force_out == brush_force) && (knife_force_out == knife_force)), "result does not match tool state")
  `TFD_ASSERT_ALWAYS(a_reset_empties, rst |=> (!out_valid && !frame_valid && (active_tool == TOOL_NONE)), "pipeline not empty after reset")

endmodule

`default_nettype wire

// ----- design/tfd_frame_check.sv -----
// Frame checker: validates letter and digits and forms the decimal force.
`default_nettype none

module tfd_frame_check (
  input  wire logic [7:0]      tool_letter,
  input  wire logic [7:0]      held_byte,
  input  wire logic [7:0]      digit_thousands,
  input  wire logic [7:0]      digit_hundreds,
  input  wire logic [7:0]      digit_tens,
  input  wire logic [7:0]      digit_ones,
  output tfd_pkg::decode_t     dec
);
  import tfd_pkg::*;

  logic  digits_ok;
  tool_t tool;

  function automatic logic is_digit(input frame_byte_t b);
    return (b >= ASCII_ZERO) && (b <= ASCII_NINE);
  endfunction

  assign digits_ok = is_digit(digit_thousands) && is_digit(digit_hundreds) &&
                     is_digit(digit_tens) && is_digit(digit_ones);

  always_comb begin
    unique case (tool_letter)
      LETTER_BRUSH: begin
        tool = TOOL_BRUSH;
      end
      LETTER_KNIFE: begin
        tool = TOOL_KNIFE;
      end
      LETTER_PIP: begin
        tool = TOOL_PIP;
      end
      default: begin
        tool = TOOL_NONE;
      end
    endcase
  end

  // For a valid ASCII digit the low nibble is the digit value.
  assign dec.force_val = force_t'(digit_thousands[3:0]) * WEIGHT_THOUSANDS
                       + force_t'(digit_hundreds[3:0])  * WEIGHT_HUNDREDS
                       + force_t'(digit_tens[3:0])      * WEIGHT_TENS
                       + force_t'(digit_ones[3:0]);

  assign dec.tool     = tool;
  assign dec.held     = (held_byte == HELD_CODE);
  assign dec.rejected = !digits_ok || (tool == TOOL_NONE);

endmodule

`default_nettype wire

// ----- bench/tool_frame_decoder_tb.sv -----
// Self-checking testbench for the tool frame decoder: directed frames, then random phases.
module tool_frame_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tfd_pkg::*;

  // Bytes that are not codes of the block but are useful as stimulus.
  localparam frame_byte_t RELEASE_CODE = 8'h00;
  localparam frame_byte_t BELOW_ZERO   = 8'h2f;
  localparam frame_byte_t ABOVE_NINE   = 8'h3a;

  localparam int ITEMS_PER_PHASE = 195;
  localparam int RANDOM_PHASES   = 10;
  localparam int MAX_GAP         = 19;
  localparam int LONG_HOLD       = 300;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 4;

  // One frame as the block sees it, with the thousands digit in the upper bits so
  // that a four-character string literal fills the digit bytes in reading order.
  typedef struct packed {
    frame_byte_t letter;
    frame_byte_t held;
    frame_byte_t thousands;
    frame_byte_t hundreds;
    frame_byte_t tens;
    frame_byte_t ones;
  } tool_frame_t;

  typedef struct packed {
    tool_t  tool;
    force_t brush;
    force_t knife;
    logic   rejected;
  } tool_status_t;

  // Tracks the tool state of the block and the status words still owed by it.
  class tool_scoreboard;
    count_t       threshold;
    count_t       change_count;
    tool_t        active;
    force_t       brush_level;
    force_t       knife_level;
    tool_status_t owed_q[$];
    int           errors;

    function new();
      threshold    = THRESHOLD_RESET;
      change_count = '0;
      active       = TOOL_NONE;
      brush_level  = '0;
      knife_level  = '0;
      errors       = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Applies one accepted frame to the tracked state and queues the status word.
    function void note_frame(tool_frame_t f);
      frame_byte_t  digit_bytes[4];
      tool_t        tool;
      bit           digits_ok;
      force_t       force_val;
      tool_status_t status;
      digit_bytes = '{f.thousands, f.hundreds, f.tens, f.ones};
      digits_ok = 1'b1;
      foreach (digit_bytes[i])
        if (digit_bytes[i] < ASCII_ZERO || digit_bytes[i] > ASCII_NINE) digits_ok = 1'b0;
      case (f.letter)
        LETTER_BRUSH: tool = TOOL_BRUSH;
        LETTER_KNIFE: tool = TOOL_KNIFE;
        LETTER_PIP:   tool = TOOL_PIP;
        default:      tool = TOOL_NONE;
      endcase
      status.rejected = !digits_ok || tool == TOOL_NONE;
      if (!status.rejected) begin
        force_val = force_t'((int'(f.thousands) - int'(ASCII_ZERO)) * int'(WEIGHT_THOUSANDS)
                           + (int'(f.hundreds) - int'(ASCII_ZERO)) * int'(WEIGHT_HUNDREDS)
                           + (int'(f.tens) - int'(ASCII_ZERO)) * int'(WEIGHT_TENS)
                           + (int'(f.ones) - int'(ASCII_ZERO)));
        if (f.held == HELD_CODE) begin
          if (active != tool) begin
            if (change_count < COUNTER_MAX) change_count = change_count + 1'b1;
          end else begin
            change_count = '0;
          end
          if (change_count > threshold) active = tool;
          if (tool == TOOL_BRUSH) brush_level = force_val;
          else if (tool == TOOL_KNIFE) knife_level = force_val;
        end else if (active == tool) begin
          active = TOOL_NONE;
        end
      end
      status.tool  = active;
      status.brush = brush_level;
      status.knife = knife_level;
      owed_q.push_back(status);
    endfunction

    // Compares one accepted status word with the oldest one owed.
    function void check_result(logic [1:0] tool, force_t brush, force_t knife, logic rejected);
      tool_status_t want;
      if (owed_q.size() == 0) begin
        $error("status word with nothing owed: tool %0d brush %0d knife %0d rejected %0d",
               tool, brush, knife, rejected);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (tool !== want.tool) begin
        $error("active_tool_out: expected %0d, got %0d", want.tool, tool);
        errors++;
      end
      if (brush !== want.brush) begin
        $error("brush_force_out: expected %0d, got %0d", want.brush, brush);
        errors++;
      end
      if (knife !== want.knife) begin
        $error("knife_force_out: expected %0d, got %0d", want.knife, knife);
        errors++;
      end
      if (rejected !== want.rejected) begin
        $error("frame_rejected: expected %0d, got %0d", want.rejected, rejected);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  frame_byte_t tool_letter = '0;
  frame_byte_t held_byte = '0;
  frame_byte_t digit_thousands = '0;
  frame_byte_t digit_hundreds = '0;
  frame_byte_t digit_tens = '0;
  frame_byte_t digit_ones = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  active_tool_out;
  force_t      brush_force_out;
  force_t      knife_force_out;
  logic        frame_rejected;

  tool_scoreboard tracker = new();

  // Idle limits of both sides for the current phase; zero gives a stretch at full rate.
  int in_gap_max  = MAX_GAP;
  int out_gap_max = MAX_GAP;
  int words_taken = 0;
  int idle_cycles = 0;

  // Random frames come in bursts on one letter, so that the change counter climbs
  // past the threshold and the active tool really moves.
  frame_byte_t burst_letter = LETTER_BRUSH;
  int          burst_left   = 0;

  tool_frame_decoder u_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .tool_letter     (tool_letter),
    .held_byte       (held_byte),
    .digit_thousands (digit_thousands),
    .digit_hundreds  (digit_hundreds),
    .digit_tens      (digit_tens),
    .digit_ones      (digit_ones),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .active_tool_out (active_tool_out),
    .brush_force_out (brush_force_out),
    .knife_force_out (knife_force_out),
    .frame_rejected  (frame_rejected)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offers one frame word after a random gap and returns at the edge that takes it.
  // When the gap is zero, valid simply stays high and only the payload changes.
  task automatic send_word(tool_frame_t f);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    tool_letter     <= f.letter;
    held_byte       <= f.held;
    digit_thousands <= f.thousands;
    digit_hundreds  <= f.hundreds;
    digit_tens      <= f.tens;
    digit_ones      <= f.ones;
    do @(posedge clk); while (!(in_valid && in_ready));
    tracker.note_frame(f);
  endtask

  // Writes the switch threshold; called only while no word is in flight.
  task automatic write_threshold(count_t value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.threshold = value;
  endtask

  // Lowers valid and waits until every owed status word has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Mostly well-formed held frames in bursts, with releases and some garbage mixed in.
  task automatic next_random_frame(output tool_frame_t f);
    int roll;
    if (burst_left == 0) begin
      case ($urandom_range(0, 2))
        0:       burst_letter = LETTER_BRUSH;
        1:       burst_letter = LETTER_KNIFE;
        default: burst_letter = LETTER_PIP;
      endcase
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    f.letter    = burst_letter;
    f.held      = HELD_CODE;
    f.thousands = frame_byte_t'($urandom_range(ASCII_ZERO, ASCII_NINE));
    f.hundreds  = frame_byte_t'($urandom_range(ASCII_ZERO, ASCII_NINE));
    f.tens      = frame_byte_t'($urandom_range(ASCII_ZERO, ASCII_NINE));
    f.ones      = frame_byte_t'($urandom_range(ASCII_ZERO, ASCII_NINE));
    roll = $urandom_range(0, 99);
    if (roll < 12) begin
      f.held = $urandom_range(0, 1) ? RELEASE_CODE : frame_byte_t'($urandom_range(2, 255));
    end else if (roll < 18) begin
      f.letter = frame_byte_t'($urandom_range(0, 255));
    end else if (roll < 24) begin
      f.held = frame_byte_t'($urandom_range(0, 255));
    end else if (roll < 30) begin
      case ($urandom_range(0, 3))
        0:       f.thousands = frame_byte_t'($urandom_range(0, 255));
        1:       f.hundreds  = frame_byte_t'($urandom_range(0, 255));
        2:       f.tens      = frame_byte_t'($urandom_range(0, 255));
        default: f.ones      = frame_byte_t'($urandom_range(0, 255));
      endcase
    end
  endtask

  // Result side: a random stall before each word, plus a long hold-off now and then
  // so that the frame register fills and the block has to drop in_ready.
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      stall = $urandom_range(0, out_gap_max);
      if (words_taken % 600 == 300) stall = LONG_HOLD;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      tracker.check_result(active_tool_out, brush_force_out, knife_force_out, frame_rejected);
      words_taken++;
    end
  end

  // Ends the run if neither channel moves a word for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("tool_frame_decoder_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    tool_frame_t f;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed frames at the reset threshold of two. Held frames cycling through
    // all three tools push the shared counter up to its top, where it must stick.
    send_word({LETTER_BRUSH, HELD_CODE, "0000"});
    send_word({LETTER_KNIFE, HELD_CODE, "9999"});
    send_word({LETTER_PIP,   HELD_CODE, "1234"});
    send_word({LETTER_BRUSH, HELD_CODE, "5678"});
    send_word({LETTER_KNIFE, HELD_CODE, "0001"});
    send_word({LETTER_PIP,   HELD_CODE, "9990"});
    send_word({LETTER_BRUSH, HELD_CODE, "4321"});
    send_word({LETTER_KNIFE, HELD_CODE, "1111"});
    // A held frame for the tool that is active clears the counter.
    send_word({LETTER_KNIFE, HELD_CODE, "2222"});
    // Releasing the active tool clears it; releasing another tool changes nothing.
    send_word({LETTER_KNIFE, RELEASE_CODE, "3333"});
    send_word({LETTER_BRUSH, RELEASE_CODE, "0000"});
    // Digit bytes just outside the legal range, and at the byte extremes.
    send_word({LETTER_BRUSH, HELD_CODE, BELOW_ZERO, "000"});
    send_word({LETTER_BRUSH, HELD_CODE, "000", ABOVE_NINE});
    send_word({LETTER_BRUSH, HELD_CODE, 32'h0000_0000});
    send_word({LETTER_KNIFE, HELD_CODE, 32'hffff_ffff});
    // Unknown letters are rejected whether held or released.
    send_word({"x", HELD_CODE, "1234"});
    send_word({8'h00, RELEASE_CODE, "1234"});
    send_word({8'hff, HELD_CODE, "9999"});
    send_word({"B", HELD_CODE, "5555"});
    // Only a held byte of exactly one counts as held.
    send_word({LETTER_PIP, 8'h02, "5555"});
    send_word({LETTER_PIP, 8'hff, "5555"});
    send_word({LETTER_PIP, HELD_CODE, "7777"});
    drain();

    // Random phases, each behind a threshold write made while the block is empty.
    // The drain at every phase boundary also makes the sender wait for all results.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       write_threshold(count_t'(0));
        1:       write_threshold(COUNTER_MAX);
        2:       write_threshold(count_t'(1));
        3:       write_threshold(THRESHOLD_RESET);
        default: write_threshold(count_t'($urandom_range(0, 7)));
      endcase
      in_gap_max  = (phase % 3 == 1) ? 0 : MAX_GAP;
      out_gap_max = (phase % 3 == 2) ? 0 : MAX_GAP;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        next_random_frame(f);
        send_word(f);
      end
      drain();
    end

    // Keep the clock running after the last drain so that a stray extra status word would still be caught.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("tool_frame_decoder_tb: clean");
    end else begin
      $display("tool_frame_decoder_tb: errors");
    end
    $finish;
  end

endmodule

// ----- tool_frame_decoder.f -----
+incdir+design
design/tfd_pkg.sv
design/tfd_frame_check.sv
design/tool_frame_decoder.sv
bench/tool_frame_decoder_tb.sv
